// ----- sv/arc_pkg.sv -----
// arc_pkg: shared types and constants of the address-resolution cache
// holds request and result structs, sequencer states and result codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package arc_pkg;

    localparam int unsigned CACHE_ENTRIES_DEF   = 16;
    localparam int unsigned PENDING_ENTRIES_DEF = 16;

    // request types
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_QUEUE  = 2'd1;
    localparam logic [1:0] REQ_REPLY  = 2'd2;
    localparam logic [1:0] REQ_TICK   = 2'd3;

    // result kinds
    localparam logic [3:0] K_HIT     = 4'd0;
    localparam logic [3:0] K_MISS    = 4'd1;
    localparam logic [3:0] K_SEND    = 4'd2;
    localparam logic [3:0] K_QUEUED  = 4'd3;
    localparam logic [3:0] K_PFULL   = 4'd4;
    localparam logic [3:0] K_RELEASE = 4'd5;
    localparam logic [3:0] K_IGNORED = 4'd6;
    localparam logic [3:0] K_UNREACH = 4'd7;
    localparam logic [3:0] K_DONE    = 4'd8;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd0;
    localparam logic [1:0] CFG_RETRY_TICKS  = 2'd1;
    localparam logic [1:0] CFG_LIFETIME     = 2'd2;

    localparam logic [3:0]  MAX_ATTEMPTS_RST = 4'd7;
    localparam logic [9:0]  RETRY_TICKS_RST  = 10'd10;
    localparam logic [15:0] LIFETIME_RST     = 16'd150;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] ip_addr;
        logic [47:0] hw_addr;
        logic [3:0]  out_iface;
    } t_req;

    typedef struct packed {
        logic [3:0]  result_kind;
        logic [31:0] res_ip;
        logic [47:0] res_mac;
        logic [3:0]  res_iface;
        logic        stored;
        logic        last;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PSCAN,
        S_CSCAN,
        S_TPEND,
        S_EMITQ,
        S_AGE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- sv/arp_resolution_cache_unit.sv -----
// arp_resolution_cache_unit: visits pending entries and reads cache entries one at a time
// (cache memory read is registered, one read port); handles one item at a time.
// Results are one-cycle strobes; the receiver cannot stall. Synchronous active-low
// reset clears valid bits and restores configuration defaults. Depends on arc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arp_resolution_cache_unit #(
    parameter int unsigned CACHE_ENTRIES   = arc_pkg::CACHE_ENTRIES_DEF,
    parameter int unsigned PENDING_ENTRIES = arc_pkg::PENDING_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire arc_pkg::t_req i_req,
    output logic             o_res_strobe,
    output arc_pkg::t_res    o_res,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import arc_pkg::*;

    localparam int unsigned CW = $clog2(CACHE_ENTRIES);
    localparam int unsigned PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam logic [CW-1:0] C_LAST = CW'(CACHE_ENTRIES - 1);
    localparam logic [PW-1:0] P_LAST = PW'(PENDING_ENTRIES - 1);

    // state and configuration
    t_state r_state, n_state;
    logic [3:0]  r_max_att;
    logic [9:0]  r_retry;
    logic [15:0] r_life;
    t_req        r_req;
    logic [31:0] r_key, n_key;

    // cache: valid bits in flops, payload in memory
    logic [CACHE_ENTRIES-1:0] r_cv, n_cv;
    logic [31:0] m_ip  [CACHE_ENTRIES];
    logic [47:0] m_mac [CACHE_ENTRIES];
    logic [15:0] m_age [CACHE_ENTRIES];
    logic [31:0] r_rd_ip;
    logic [47:0] r_rd_mac;
    logic [15:0] r_rd_age;
    logic [CW-1:0] r_cidx, n_cidx, r_ridx;
    logic r_issue, n_issue, r_rdv, n_rdv, r_rdlast;
    logic r_cff, n_cff;
    logic [CW-1:0] r_cfidx, n_cfidx;

    // cache write port
    logic          wi_en, wa_en;
    logic [CW-1:0] w_addr;
    logic [15:0]   w_age;

    // pending table in flops
    logic [PENDING_ENTRIES-1:0] r_pv, n_pv;
    logic [31:0] r_pip    [PENDING_ENTRIES];
    logic [3:0]  r_psends [PENDING_ENTRIES];
    logic [9:0]  r_ptimer [PENDING_ENTRIES];
    logic [3:0]  r_piface [PENDING_ENTRIES];
    logic [PW-1:0] r_pidx, n_pidx, r_pmatch, n_pmatch, r_pfidx, n_pfidx;
    logic r_pff, n_pff;
    logic          pw_open, pw_tick;
    logic [3:0]    pw_sends;
    logic [9:0]    pw_timer;

    // result emission
    logic r_strobe;
    t_res r_res, e_res;
    logic e_v;

    // shared compare unit signals
    logic        cur_pv, p_last, p_match, rd_cv, rd_match, c_end, c_stay;
    logic [31:0] cur_pip;
    logic [9:0]  t_inc;
    logic [15:0] age_inc;

    assign cur_pv   = r_pv[r_pidx];
    assign cur_pip  = r_pip[r_pidx];
    assign p_last   = (r_pidx == P_LAST);
    assign p_match  = cur_pv && (cur_pip == r_req.ip_addr);
    assign rd_cv    = r_cv[r_ridx];
    assign rd_match = r_rdv && rd_cv && (r_rd_ip == r_key);
    assign c_end    = rd_match || (r_rdv && r_rdlast);
    assign t_inc    = (r_ptimer[r_pidx] == 10'h3FF) ? r_ptimer[r_pidx]
                                                    : r_ptimer[r_pidx] + 10'd1;
    assign age_inc  = (r_rd_age == 16'hFFFF) ? r_rd_age : r_rd_age + 16'd1;

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_req.req_type) inside
                        REQ_LOOKUP: n_state = S_CSCAN;
                        REQ_QUEUE, REQ_REPLY: n_state = S_PSCAN;
                        default: n_state = S_TPEND;
                    endcase
                end
            end
            S_PSCAN: begin
                if (p_match) begin
                    n_state = (r_req.req_type == REQ_REPLY) ? S_CSCAN : S_IDLE;
                end else if (p_last) begin
                    if (r_req.req_type == REQ_QUEUE && (r_pff || !cur_pv))
                        n_state = S_EMITQ;
                    else
                        n_state = S_IDLE;
                end
            end
            S_CSCAN: begin
                if (c_end) begin
                    if (r_req.req_type == REQ_TICK)
                        n_state = p_last ? S_AGE : S_TPEND;
                    else
                        n_state = S_IDLE;
                end
            end
            S_TPEND: begin
                if (cur_pv)
                    n_state = S_CSCAN;
                else if (p_last)
                    n_state = S_AGE;
            end
            S_EMITQ: n_state = S_IDLE;
            S_AGE: begin
                if (r_rdv && r_rdlast)
                    n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer datapath and result selection
    always_comb begin
        n_key    = r_key;
        n_cv     = r_cv;
        n_pv     = r_pv;
        n_pidx   = r_pidx;
        n_pmatch = r_pmatch;
        n_pff    = r_pff;
        n_pfidx  = r_pfidx;
        n_cff    = r_cff;
        n_cfidx  = r_cfidx;
        wi_en    = 1'b0;
        wa_en    = 1'b0;
        w_addr   = r_ridx;
        w_age    = 16'd0;
        pw_open  = 1'b0;
        pw_tick  = 1'b0;
        pw_sends = r_psends[r_pidx];
        pw_timer = r_ptimer[r_pidx];
        e_v      = 1'b0;
        e_res    = '0;
        c_stay   = (r_state == n_state) && (r_state == S_CSCAN || r_state == S_AGE);

        // cache read address sequencing
        if (r_state != n_state && (n_state == S_CSCAN || n_state == S_AGE)) begin
            n_cidx  = '0;
            n_issue = 1'b1;
            n_cff   = 1'b0;
        end else if (c_stay && r_issue) begin
            n_cidx  = (r_cidx == C_LAST) ? r_cidx : r_cidx + CW'(1);
            n_issue = (r_cidx != C_LAST);
        end else begin
            n_cidx  = r_cidx;
            n_issue = c_stay ? r_issue : 1'b0;
        end
        n_rdv = c_stay && r_issue;

        unique case (r_state)
            S_IDLE: begin
                n_pidx = '0;
                n_pff  = 1'b0;
                n_key  = i_req.ip_addr;
            end
            S_PSCAN: begin
                if (!cur_pv && !r_pff) begin
                    n_pff   = 1'b1;
                    n_pfidx = r_pidx;
                end
                if (p_match) begin
                    n_pmatch = r_pidx;
                    if (r_req.req_type == REQ_QUEUE) begin
                        e_v = 1'b1;
                        e_res.result_kind = K_QUEUED;
                        e_res.res_ip = r_req.ip_addr;
                        e_res.last = 1'b1;
                    end
                end else if (p_last) begin
                    e_v = 1'b1;
                    e_res.res_ip = r_req.ip_addr;
                    if (r_req.req_type == REQ_REPLY) begin
                        e_res.result_kind = K_IGNORED;
                        e_res.last = 1'b1;
                    end else if (r_pff || !cur_pv) begin
                        pw_open = 1'b1;
                        n_pv[r_pff ? r_pfidx : r_pidx] = 1'b1;
                        e_res.result_kind = K_SEND;
                        e_res.res_iface = r_req.out_iface;
                    end else begin
                        e_res.result_kind = K_PFULL;
                        e_res.last = 1'b1;
                    end
                end else begin
                    n_pidx = r_pidx + PW'(1);
                end
            end
            S_CSCAN: begin
                if (r_rdv && !rd_cv && !r_cff) begin
                    n_cff   = 1'b1;
                    n_cfidx = r_ridx;
                end
                if (c_end) begin
                    unique case (r_req.req_type)
                        REQ_LOOKUP: begin
                            e_v = 1'b1;
                            e_res.result_kind = rd_match ? K_HIT : K_MISS;
                            e_res.res_ip = r_key;
                            e_res.res_mac = rd_match ? r_rd_mac : 48'd0;
                            e_res.last = 1'b1;
                        end
                        REQ_REPLY: begin
                            n_pv[r_pmatch] = 1'b0;
                            e_v = 1'b1;
                            e_res.result_kind = K_RELEASE;
                            e_res.res_ip = r_key;
                            e_res.res_mac = r_req.hw_addr;
                            e_res.last = 1'b1;
                            if (rd_match || r_cff || !rd_cv) begin
                                wi_en = 1'b1;
                                wa_en = 1'b1;
                                w_addr = rd_match ? r_ridx : (r_cff ? r_cfidx : r_ridx);
                                n_cv[w_addr] = 1'b1;
                                e_res.stored = 1'b1;
                            end
                        end
                        default: begin
                            // pending entry whose address is not resolved yet
                            if (!rd_match) begin
                                if (r_psends[r_pidx] >= r_max_att) begin
                                    n_pv[r_pidx] = 1'b0;
                                    e_v = 1'b1;
                                    e_res.result_kind = K_UNREACH;
                                    e_res.res_ip = cur_pip;
                                    e_res.res_iface = r_piface[r_pidx];
                                end else begin
                                    pw_tick = 1'b1;
                                    pw_timer = t_inc;
                                    if (t_inc >= r_retry) begin
                                        pw_timer = 10'd0;
                                        if (r_psends[r_pidx] != 4'hF)
                                            pw_sends = r_psends[r_pidx] + 4'd1;
                                        e_v = 1'b1;
                                        e_res.result_kind = K_SEND;
                                        e_res.res_ip = cur_pip;
                                        e_res.res_iface = r_piface[r_pidx];
                                    end
                                end
                            end
                            if (!p_last)
                                n_pidx = r_pidx + PW'(1);
                        end
                    endcase
                end
            end
            S_TPEND: begin
                n_key = cur_pip;
                if (!cur_pv && !p_last)
                    n_pidx = r_pidx + PW'(1);
            end
            S_EMITQ: begin
                e_v = 1'b1;
                e_res.result_kind = K_QUEUED;
                e_res.res_ip = r_req.ip_addr;
                e_res.last = 1'b1;
            end
            S_AGE: begin
                if (r_rdv && rd_cv) begin
                    wa_en = 1'b1;
                    w_age = age_inc;
                    if (age_inc >= r_life)
                        n_cv[r_ridx] = 1'b0;
                end
            end
            S_DONE: begin
                e_v = 1'b1;
                e_res.result_kind = K_DONE;
                e_res.last = 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cv      <= '0;
            r_pv      <= '0;
            r_strobe  <= 1'b0;
            r_issue   <= 1'b0;
            r_rdv     <= 1'b0;
            r_max_att <= MAX_ATTEMPTS_RST;
            r_retry   <= RETRY_TICKS_RST;
            r_life    <= LIFETIME_RST;
        end else begin
            r_state  <= n_state;
            r_cv     <= n_cv;
            r_pv     <= n_pv;
            r_strobe <= e_v;
            r_issue  <= n_issue;
            r_rdv    <= n_rdv;
            // configuration transfer
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MAX_ATTEMPTS: r_max_att <= i_cfg_data[3:0];
                    CFG_RETRY_TICKS:  r_retry   <= i_cfg_data[9:0];
                    CFG_LIFETIME:     r_life    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (start && !busy)
            r_req <= i_req;
        r_key    <= n_key;
        r_cidx   <= n_cidx;
        r_ridx   <= r_cidx;
        r_rdlast <= (r_cidx == C_LAST);
        r_pidx   <= n_pidx;
        r_pmatch <= n_pmatch;
        r_pff    <= n_pff;
        r_pfidx  <= n_pfidx;
        r_cff    <= n_cff;
        r_cfidx  <= n_cfidx;
        r_res    <= e_res;
    end

    // pending entry writes
    always_ff @(posedge i_clk) begin
        if (pw_open) begin
            r_pip[r_pff ? r_pfidx : r_pidx]    <= r_req.ip_addr;
            r_psends[r_pff ? r_pfidx : r_pidx] <= 4'd1;
            r_ptimer[r_pff ? r_pfidx : r_pidx] <= 10'd0;
            r_piface[r_pff ? r_pfidx : r_pidx] <= r_req.out_iface;
        end
        if (pw_tick) begin
            r_psends[r_pidx] <= pw_sends;
            r_ptimer[r_pidx] <= pw_timer;
        end
    end

    // cache memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wi_en) begin
            m_ip[w_addr]  <= r_key;
            m_mac[w_addr] <= r_req.hw_addr;
        end
        if (wa_en)
            m_age[w_addr] <= w_age;
        r_rd_ip  <= m_ip[r_cidx];
        r_rd_mac <= m_mac[r_cidx];
        r_rd_age <= m_age[r_cidx];
    end

endmodule

`default_nettype wire
